// ===== hw/rtl/tms_pkg.sv =====
// Package for the tone melody sequencer: table geometry, divider widths,
// register indexes, action codes and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps

package tms_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int ENTRY_W     = 48;

    localparam int DIVD_W    = 18;
    localparam int DIVS_W    = 16;
    localparam int DIV_CNT_W = $clog2(DIVD_W + 1);

    localparam logic [DIVD_W-1:0] WHOLE_NOTE_MS = 18'd240000;
    localparam logic [26:0]       US_PER_MS     = 27'd1000;

    localparam int PADDR_W = 4;

    typedef enum logic [1:0] {
        REG_TEMPO = 2'd0,
        REG_COUNT = 2'd1,
        REG_GAP   = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_START = 2'd2,
        ACT_STOP  = 2'd3
    } t_action;

    typedef struct packed {
        logic [15:0] tempo;
        logic [5:0]  count;
        logic        gap_en;
    } t_cfg;

    typedef struct packed {
        logic capture;
        logic div_start_w;
        logic div_start_l;
        logic wr_entry;
        logic do_start;
        logic do_stop;
        logic tick_end;
        logic tick_add;
        logic tick_adv;
        logic rd_req;
        logic arm;
        logic scale;
        logic emit;
    } t_cmd;

    typedef struct packed {
        t_action action;
        logic    conv_direct;
        logic    div_busy;
        logic    end_cond;
        logic    pend_nz;
        logic    reached;
        logic    out_free;
    } t_sts;

endpackage

// ===== hw/rtl/tone_melody_sequencer.sv =====
// Top level of the tone melody sequencer: configuration port, controller and datapath.
// Depends on tms_pkg, tms_regs, tms_ctrl and tms_dp.
`timescale 1ns / 1ps

// Each request is taken when o_ready is high and produces one result in an output
// register, so a new request may be taken while the previous result waits. A load
// goes straight to S_WRITE when the tempo or the duration code is zero; otherwise
// the whole-note time and then the note length each pass through the shared
// restoring divider at one quotient bit per cycle. The note table resets to zero
// through per-entry valid bits, so no clearing pass follows reset.
module tone_melody_sequencer
    import tms_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_action,
    input  logic [31:0]        i_tick_delta_us,
    input  logic [5:0]         i_entry_index,
    input  logic [15:0]        i_note_freq,
    input  logic signed [15:0] i_duration_code,
    input  logic [15:0]        i_gap_ms,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_tone_start,
    output logic [15:0]        o_tone_freq,
    output logic [15:0]        o_tone_ms,
    output logic               o_silence,
    output logic               o_finished,
    output logic               o_playing
);

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    tms_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tms_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_ready (o_ready)
    );

    tms_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_action        (i_action),
        .i_tick_delta_us (i_tick_delta_us),
        .i_entry_index   (i_entry_index),
        .i_note_freq     (i_note_freq),
        .i_duration_code (16'(i_duration_code)),
        .i_gap_ms        (i_gap_ms),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_tone_start    (o_tone_start),
        .o_tone_freq     (o_tone_freq),
        .o_tone_ms       (o_tone_ms),
        .o_silence       (o_silence),
        .o_finished      (o_finished),
        .o_playing       (o_playing)
    );

endmodule

// ===== hw/rtl/tms_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module tms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/tms_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the length conversion.
// Depends on tms_pkg.
`timescale 1ns / 1ps

module tms_div
    import tms_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [DIVS_W-1:0] i_divisor,
    output logic              o_busy,
    output logic [DIVD_W-1:0] o_quotient
);

    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [DIVS_W-1:0]    r_rem, n_rem;
    logic [DIVD_W-1:0]    r_quo, n_quo;
    logic [DIVS_W-1:0]    r_den;
    logic [DIVS_W:0]      rem_sh;
    logic [DIVS_W:0]      diff;
    logic                 ge;

    always_comb begin
        rem_sh = {r_rem, r_quo[DIVD_W-1]};
        ge     = rem_sh >= {1'b0, r_den};
        diff   = rem_sh - {1'b0, r_den};
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        if (i_start) begin
            n_cnt = DIV_CNT_W'(DIVD_W);
            n_rem = '0;
            n_quo = i_dividend;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            n_rem = ge ? diff[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
            n_quo = {r_quo[DIVD_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_start) begin
            r_den <= i_divisor;
        end
    end

    assign o_busy     = r_cnt != '0;
    assign o_quotient = r_quo;

endmodule

// ===== hw/rtl/tms_regs.sv =====
// APB-style configuration registers: tempo, note count and gap enable.
// Depends on tms_pkg.
`timescale 1ns / 1ps

module tms_regs
    import tms_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg r_cfg, n_cfg;
    logic wr;

    assign wr = psel && penable && pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (wr) begin
            unique case (paddr[3:2])
                REG_TEMPO: n_cfg.tempo  = pwdata[15:0];
                REG_COUNT: n_cfg.count  = pwdata[5:0];
                REG_GAP:   n_cfg.gap_en = pwdata[0];
                default:   n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_TEMPO: prdata = {16'd0, r_cfg.tempo};
            REG_COUNT: prdata = {26'd0, r_cfg.count};
            REG_GAP:   prdata = {31'd0, r_cfg.gap_en};
            default:   prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

endmodule

// ===== hw/rtl/tms_ctrl.sv =====
// Controller state machine that sequences each request through the datapath.
// Depends on tms_pkg.
`timescale 1ns / 1ps

module tms_ctrl
    import tms_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_ready
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_EXEC  = 9'b000000010,
        S_DIV1  = 9'b000000100,
        S_DIV2  = 9'b000001000,
        S_WRITE = 9'b000010000,
        S_CMP   = 9'b000100000,
        S_ARM   = 9'b001000000,
        S_SCALE = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_sts.action)
                    ACT_LOAD: begin
                        if (i_sts.conv_direct) begin
                            n_state = S_WRITE;
                        end else begin
                            o_cmd.div_start_w = 1'b1;
                            n_state           = S_DIV1;
                        end
                    end
                    ACT_START: begin
                        o_cmd.do_start = 1'b1;
                        n_state        = S_DONE;
                    end
                    ACT_STOP: begin
                        o_cmd.do_stop = 1'b1;
                        n_state       = S_DONE;
                    end
                    default: begin
                        if (i_sts.end_cond) begin
                            o_cmd.tick_end = 1'b1;
                            n_state        = S_DONE;
                        end else if (i_sts.pend_nz) begin
                            o_cmd.tick_add = 1'b1;
                            n_state        = S_CMP;
                        end else begin
                            o_cmd.tick_add = 1'b1;
                            o_cmd.rd_req   = 1'b1;
                            n_state        = S_ARM;
                        end
                    end
                endcase
            end
            S_DIV1: begin
                if (!i_sts.div_busy) begin
                    o_cmd.div_start_l = 1'b1;
                    n_state           = S_DIV2;
                end
            end
            S_DIV2: begin
                if (!i_sts.div_busy) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.wr_entry = 1'b1;
                n_state        = S_DONE;
            end
            S_CMP: begin
                o_cmd.tick_adv = i_sts.reached;
                n_state        = S_DONE;
            end
            S_ARM: begin
                o_cmd.arm = 1'b1;
                n_state   = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = r_state == S_IDLE;

endmodule

// ===== hw/rtl/tms_dp.sv =====
// Datapath: request capture, length conversion, note table, playback state
// and result register. Depends on tms_pkg, tms_div and tms_ram.
`timescale 1ns / 1ps

module tms_dp
    import tms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_tick_delta_us,
    input  logic [5:0]  i_entry_index,
    input  logic [15:0] i_note_freq,
    input  logic [15:0] i_duration_code,
    input  logic [15:0] i_gap_ms,
    input  logic        i_ready,
    output logic        o_valid,
    output logic        o_tone_start,
    output logic [15:0] o_tone_freq,
    output logic [15:0] o_tone_ms,
    output logic        o_silence,
    output logic        o_finished,
    output logic        o_playing
);

    t_action     r_action;
    logic [31:0] r_delta;
    logic [5:0]  r_idx;
    logic [15:0] r_freq_in;
    logic [15:0] r_code;
    logic [15:0] r_gap_in;

    logic        r_res_start, n_res_start;
    logic [15:0] r_res_freq, n_res_freq;
    logic [15:0] r_res_ms, n_res_ms;
    logic        r_res_sil, n_res_sil;
    logic        r_res_fin, n_res_fin;

    logic [6:0]  r_ptr, n_ptr;
    logic        r_run, n_run;
    logic [31:0] r_elapsed, n_elapsed;
    logic [16:0] r_pend, n_pend;
    logic [26:0] r_wait_us, n_wait_us;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic        r_rd_valid;

    logic        r_out_valid;
    logic        r_out_start;
    logic [15:0] r_out_freq;
    logic [15:0] r_out_ms;
    logic        r_out_sil;
    logic        r_out_fin;
    logic        r_out_play;

    logic              code_neg;
    logic [15:0]       code_mag;
    logic [15:0]       direct_len;
    logic [DIVD_W-1:0] quotient;
    logic [19:0]       dot_sum;
    logic [19:0]       div_len;
    logic [15:0]       sat_len;
    logic [15:0]       wr_len;
    logic              wr_ok;
    logic              div_busy;
    logic [ENTRY_W-1:0] rdata;
    logic [ENTRY_W-1:0] entry;
    logic [32:0]       elapsed_sum;
    logic              out_free;

    assign code_neg   = r_code[15];
    assign code_mag   = code_neg ? (~r_code + 16'd1) : r_code;
    assign direct_len = (i_cfg.tempo == 16'd0 && !code_neg) ? r_code : 16'd0;
    assign dot_sum    = {2'b00, quotient} + {1'b0, quotient, 1'b0};
    assign div_len    = code_neg ? {1'b0, dot_sum[19:1]} : {2'b00, quotient};
    assign sat_len    = (div_len[19:16] != 4'd0) ? 16'hFFFF : div_len[15:0];
    assign wr_len     = o_sts.conv_direct ? direct_len : sat_len;
    assign wr_ok      = 32'(r_idx) < TABLE_DEPTH;

    tms_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start_w || i_cmd.div_start_l),
        .i_dividend (i_cmd.div_start_w ? WHOLE_NOTE_MS : quotient),
        .i_divisor  (i_cmd.div_start_w ? i_cfg.tempo : code_mag),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    tms_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_entry && wr_ok),
        .i_waddr (ADDR_W'(r_idx)),
        .i_wdata ({r_freq_in, wr_len, r_gap_in}),
        .i_re    (i_cmd.rd_req),
        .i_raddr (ADDR_W'(r_ptr)),
        .o_rdata (rdata)
    );

    assign entry       = r_rd_valid ? rdata : '0;
    assign elapsed_sum = {1'b0, r_elapsed} + {1'b0, r_delta};
    assign out_free    = !r_out_valid || i_ready;

    always_comb begin
        o_sts.action      = r_action;
        o_sts.conv_direct = (i_cfg.tempo == 16'd0) || (code_mag == 16'd0);
        o_sts.div_busy    = div_busy;
        o_sts.end_cond    = !r_run || (r_ptr >= {1'b0, i_cfg.count})
                            || (32'(r_ptr) >= TABLE_DEPTH);
        o_sts.pend_nz     = r_pend != 17'd0;
        o_sts.reached     = r_elapsed >= {5'd0, r_wait_us};
        o_sts.out_free    = out_free;
    end

    always_comb begin
        n_res_start = r_res_start;
        n_res_freq  = r_res_freq;
        n_res_ms    = r_res_ms;
        n_res_sil   = r_res_sil;
        n_res_fin   = r_res_fin;
        n_ptr       = r_ptr;
        n_run       = r_run;
        n_elapsed   = r_elapsed;
        n_pend      = r_pend;
        n_wait_us   = r_wait_us;
        if (i_cmd.capture) begin
            n_res_start = 1'b0;
            n_res_freq  = 16'd0;
            n_res_ms    = 16'd0;
            n_res_sil   = 1'b0;
            n_res_fin   = 1'b0;
        end
        if (i_cmd.do_start) begin
            n_run = 1'b1;
        end
        if (i_cmd.do_stop || i_cmd.tick_end) begin
            n_run     = 1'b0;
            n_ptr     = 7'd0;
            n_elapsed = 32'd0;
            n_pend    = 17'd0;
            n_wait_us = 27'd0;
        end
        if (i_cmd.tick_end) begin
            n_res_sil = 1'b1;
            n_res_fin = 1'b1;
        end
        if (i_cmd.tick_add) begin
            n_elapsed = elapsed_sum[32] ? 32'hFFFF_FFFF : elapsed_sum[31:0];
        end
        if (i_cmd.tick_adv) begin
            n_res_sil = 1'b1;
            n_pend    = 17'd0;
            n_ptr     = r_ptr + 7'd1;
            n_elapsed = 32'd0;
        end
        if (i_cmd.arm) begin
            n_res_start = 1'b1;
            n_res_freq  = entry[47:32];
            n_res_ms    = entry[31:16];
            n_pend      = {1'b0, entry[31:16]}
                          + (i_cfg.gap_en ? {1'b0, entry[15:0]} : 17'd0);
            n_elapsed   = 32'd0;
        end
        if (i_cmd.scale) begin
            n_wait_us = 27'(27'(r_pend) * US_PER_MS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr       <= '0;
            r_run       <= 1'b0;
            r_elapsed   <= '0;
            r_pend      <= '0;
            r_wait_us   <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_ptr     <= n_ptr;
            r_run     <= n_run;
            r_elapsed <= n_elapsed;
            r_pend    <= n_pend;
            r_wait_us <= n_wait_us;
            if (i_cmd.wr_entry && wr_ok) begin
                r_valid[ADDR_W'(r_idx)] <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action  <= t_action'(i_action);
            r_delta   <= i_tick_delta_us;
            r_idx     <= i_entry_index;
            r_freq_in <= i_note_freq;
            r_code    <= i_duration_code;
            r_gap_in  <= i_gap_ms;
        end
        if (i_cmd.rd_req) begin
            r_rd_valid <= r_valid[ADDR_W'(r_ptr)];
        end
        r_res_start <= n_res_start;
        r_res_freq  <= n_res_freq;
        r_res_ms    <= n_res_ms;
        r_res_sil   <= n_res_sil;
        r_res_fin   <= n_res_fin;
        if (i_cmd.emit) begin
            r_out_start <= r_res_start;
            r_out_freq  <= r_res_freq;
            r_out_ms    <= r_res_ms;
            r_out_sil   <= r_res_sil;
            r_out_fin   <= r_res_fin;
            r_out_play  <= r_run;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_tone_start = r_out_start;
    assign o_tone_freq  = r_out_freq;
    assign o_tone_ms    = r_out_ms;
    assign o_silence    = r_out_sil;
    assign o_finished   = r_out_fin;
    assign o_playing    = r_out_play;

endmodule

// ===== hw/rtl/tms_checker.sv =====
// Port-level assertions for the tone melody sequencer and the bind that attaches them.
// Depends on tone_melody_sequencer.
`timescale 1ns / 1ps

module tms_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input logic               o_tone_start,
    input logic [15:0]        o_tone_freq,
    input logic [15:0]        o_tone_ms,
    input logic               o_silence,
    input logic               o_finished,
    input logic               o_playing
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_tone_freq) && $stable(o_tone_ms)
            && $stable(o_tone_start) && $stable(o_playing))
        else $error("Result changed while stalled.");

    a_start_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_tone_start |-> !o_silence && !o_finished)
        else $error("A tone start came with silence or finished.");

    a_finish_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_finished |-> o_silence && !o_playing)
        else $error("Finished without silence, or still playing.");

    a_no_tone_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_tone_start |-> o_tone_freq == 16'd0 && o_tone_ms == 16'd0)
        else $error("Tone fields nonzero without a tone start.");

endmodule

bind tone_melody_sequencer tms_checker u_tms_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for tone_melody_sequencer: directed and random requests
// over valid/ready with random idling, APB register writes, and a built-in predictor.
// Depends on tms_pkg and the tone_melody_sequencer RTL.
`timescale 1ns / 1ps

module tb_top;
    import tms_pkg::*;

    typedef struct packed {
        t_action     action;
        logic [31:0] delta;
        logic [5:0]  index;
        logic [15:0] freq;
        logic [15:0] code;
        logic [15:0] gap;
    } t_tone_req;

    typedef struct packed {
        logic        start;
        logic [15:0] freq;
        logic [15:0] ms;
        logic        silence;
        logic        finished;
        logic        playing;
    } t_tone_res;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [1:0]         i_action = '0;
    logic [31:0]        i_tick_delta_us = '0;
    logic [5:0]         i_entry_index = '0;
    logic [15:0]        i_note_freq = '0;
    logic signed [15:0] i_duration_code = '0;
    logic [15:0]        i_gap_ms = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic               o_tone_start;
    logic [15:0]        o_tone_freq;
    logic [15:0]        o_tone_ms;
    logic               o_silence;
    logic               o_finished;
    logic               o_playing;

    tone_melody_sequencer u_top (.*);

    logic [15:0] melody_freq [TABLE_DEPTH];
    logic [15:0] melody_len [TABLE_DEPTH];
    logic [15:0] melody_gap [TABLE_DEPTH];
    int unsigned note_ptr = 0;
    bit          melody_running = 1'b0;
    logic [31:0] elapsed_us = '0;
    int unsigned wait_ms = 0;
    logic [15:0] cfg_tempo = '0;
    logic [5:0]  cfg_count = '0;
    bit          cfg_gap_en = 1'b0;

    t_tone_res   tone_results_due[$];
    int unsigned items_sent = 0;
    int unsigned tone_mismatches = 0;
    bit          no_idle = 1'b0;
    int unsigned rx_hold_cycles = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            melody_freq[i] = '0;
            melody_len[i] = '0;
            melody_gap[i] = '0;
        end
    end

    function automatic void halt_melody();
        melody_running = 1'b0;
        note_ptr = 0;
        elapsed_us = '0;
        wait_ms = 0;
    endfunction

    function automatic t_tone_res predict_tone_step(t_tone_req r);
        t_tone_res   res;
        logic        neg;
        logic [16:0] mag;
        int unsigned len;
        logic [32:0] sum;
        res = '0;
        case (r.action)
            ACT_LOAD: begin
                neg = r.code[15];
                mag = neg ? (17'h10000 - {1'b0, r.code}) : {1'b0, r.code};
                if (cfg_tempo == 0) begin
                    len = neg ? 0 : 32'(mag);
                end else if (mag == 0) begin
                    len = 0;
                end else begin
                    len = (32'd240000 / 32'(cfg_tempo)) / 32'(mag);
                    if (neg) begin
                        len = (len * 3) / 2;
                    end
                end
                if (len > 65535) begin
                    len = 65535;
                end
                melody_freq[r.index] = r.freq;
                melody_len[r.index] = len[15:0];
                melody_gap[r.index] = r.gap;
            end
            ACT_START: begin
                melody_running = 1'b1;
            end
            ACT_STOP: begin
                halt_melody();
            end
            default: begin
                if (!melody_running || note_ptr >= cfg_count) begin
                    res.silence = 1'b1;
                    res.finished = 1'b1;
                    halt_melody();
                end else begin
                    sum = {1'b0, elapsed_us} + {1'b0, r.delta};
                    elapsed_us = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    if (wait_ms != 0) begin
                        if ({32'b0, elapsed_us} >= 64'(wait_ms) * 64'd1000) begin
                            res.silence = 1'b1;
                            wait_ms = 0;
                            note_ptr++;
                            elapsed_us = '0;
                        end
                    end else begin
                        res.start = 1'b1;
                        res.freq = melody_freq[note_ptr];
                        res.ms = melody_len[note_ptr];
                        wait_ms = melody_len[note_ptr] + (cfg_gap_en ? melody_gap[note_ptr] : 0);
                        elapsed_us = '0;
                    end
                end
            end
        endcase
        res.playing = melody_running;
        return res;
    endfunction

    function automatic t_tone_req random_request(t_action act);
        t_tone_req r;
        r.action = act;
        r.delta = $urandom;
        r.index = 6'($urandom);
        r.freq = 16'($urandom);
        r.code = 16'($urandom);
        r.gap = 16'($urandom);
        return r;
    endfunction

    task automatic send_request(t_tone_req r);
        int unsigned idle;
        idle = no_idle ? 0 : $urandom_range(0, 9);
        if (idle > 0) begin
            i_valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= r.action;
        i_tick_delta_us <= r.delta;
        i_entry_index <= r.index;
        i_note_freq <= r.freq;
        i_duration_code <= r.code;
        i_gap_ms <= r.gap;
        do @(posedge i_clk); while (!o_ready);
        tone_results_due.push_back(predict_tone_step(r));
        items_sent++;
    endtask

    task automatic send_tick(logic [31:0] delta);
        t_tone_req r;
        r = random_request(ACT_TICK);
        r.delta = delta;
        send_request(r);
    endtask

    task automatic send_load(logic [5:0] index, logic [15:0] freq, logic [15:0] code,
                             logic [15:0] gap);
        t_tone_req r;
        r = random_request(ACT_LOAD);
        r.index = index;
        r.freq = freq;
        r.code = code;
        r.gap = gap;
        send_request(r);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (tone_results_due.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] value);
        paddr <= PADDR_W'({idx, 2'b00});
        pwdata <= value;
        pwrite <= 1'b1;
        psel <= 1'b1;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_TEMPO: cfg_tempo = value[15:0];
            REG_COUNT: cfg_count = value[5:0];
            default:   cfg_gap_en = value[0];
        endcase
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_tone_res got;
        t_tone_res want;
        bit        stray;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_tone_start, o_tone_freq, o_tone_ms, o_silence, o_finished, o_playing};
            stray = (tone_results_due.size() == 0);
            want = stray ? '0 : tone_results_due.pop_front();
            if (stray || got !== want) begin
                tone_mismatches++;
                if (tone_mismatches <= 10) begin
                    $display({"%s at %0t: expected start=%0d freq=%0d ms=%0d sil=%0d",
                              " fin=%0d play=%0d"},
                             stray ? "Result with no request pending" : "Result mismatch",
                             $realtime, want.start, want.freq, want.ms, want.silence,
                             want.finished, want.playing);
                    $display("    actual start=%0d freq=%0d ms=%0d sil=%0d fin=%0d play=%0d",
                             got.start, got.freq, got.ms, got.silence, got.finished,
                             got.playing);
                end
            end
        end
    end

    initial begin
        int unsigned stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 9);
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic test_idle_after_reset();
        send_tick(32'd0);
        send_request(random_request(ACT_START));
        send_tick($urandom);
        send_request(random_request(ACT_STOP));
    endtask

    task automatic test_length_extremes();
        wait_idle();
        write_reg(REG_TEMPO, 32'd1);
        write_reg(REG_COUNT, 32'd3);
        write_reg(REG_GAP, 32'd1);
        send_load(6'd0, 16'hFFFF, 16'sd1, 16'hFFFF);
        send_load(6'd1, 16'h0000, 16'h8000, 16'h0000);
        send_load(6'd2, 16'h1234, 16'h0000, 16'h0000);
        send_request(random_request(ACT_START));
        send_tick(32'd0);
        send_tick(32'd100_000_000);
        send_tick(32'hFFFF_FFFF);
        send_tick(32'd5);
        send_tick(32'd9_999);
        send_tick(32'd1);
        send_tick(32'd0);
        send_tick(32'd123);
        send_request(random_request(ACT_START));
        send_request(random_request(ACT_STOP));
        send_tick(32'd0);
    endtask

    task automatic test_table_edges();
        wait_idle();
        write_reg(REG_TEMPO, 32'd0);
        write_reg(REG_COUNT, 32'd63);
        write_reg(REG_GAP, 32'd0);
        send_load(6'd63, 16'hA5A5, -16'sd5, 16'h5A5A);
        send_load(6'd0, 16'd440, 16'sd32767, 16'd7);
        send_request(random_request(ACT_START));
        send_tick(32'd0);
        send_tick(32'd32_767_000);
        send_request(random_request(ACT_STOP));
        wait_idle();
        write_reg(REG_TEMPO, 32'd65535);
        send_load(6'd0, 16'd1000, -16'sd1, 16'd0);
        send_request(random_request(ACT_START));
        send_tick(32'd0);
        send_request(random_request(ACT_STOP));
    endtask

    task automatic test_backpressure();
        wait_idle();
        no_idle = 1'b1;
        rx_hold_cycles = 300;
        send_request(random_request(ACT_START));
        repeat (23) send_request(random_request(t_action'($urandom_range(0, 3))));
        no_idle = 1'b0;
    endtask

    task automatic test_random_melodies(int unsigned budget);
        int unsigned first;
        int unsigned ticks;
        int unsigned pick;
        logic [15:0] tempo;
        logic [5:0]  count;
        logic [15:0] code;
        logic [31:0] delta;
        first = items_sent;
        while (items_sent < first + budget) begin
            wait_idle();
            pick = $urandom_range(0, 19);
            if (pick < 5) tempo = 16'd0;
            else if (pick < 7) tempo = 16'hFFFF;
            else if (pick == 7) tempo = 16'd1;
            else if (pick < 16) tempo = 16'($urandom_range(40, 300));
            else tempo = 16'($urandom);
            pick = $urandom_range(0, 19);
            if (pick == 0) count = 6'd0;
            else if (pick == 1) count = 6'd63;
            else count = 6'($urandom_range(1, 10));
            write_reg(REG_TEMPO, {16'b0, tempo});
            write_reg(REG_COUNT, {26'b0, count});
            write_reg(REG_GAP, {31'b0, 1'($urandom_range(0, 1))});
            no_idle = ($urandom_range(0, 3) == 0);

            for (int i = 0; i < cfg_count; i++) begin
                case ($urandom_range(0, 4))
                    0, 1: begin
                        code = 16'(1 << $urandom_range(0, 5));
                        if ($urandom_range(0, 2) == 0) code = -code;
                    end
                    2: code = 16'($urandom_range(0, 600));
                    3: code = 16'($urandom);
                    default: code = -16'($urandom_range(1, 64));
                endcase
                send_load(6'(i), 16'($urandom), code,
                          ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 200)));
            end
            if ($urandom_range(0, 4) == 0) send_request(random_request(ACT_LOAD));
            send_request(random_request(ACT_START));

            ticks = 0;
            while (melody_running && ticks < 4 * cfg_count + 8) begin
                if ($urandom_range(0, 11) == 0) begin
                    send_request(random_request(t_action'($urandom_range(0, 3))));
                end else begin
                    case ($urandom_range(0, 9))
                        0: delta = 32'd0;
                        1: delta = 32'hFFFF_FFFF;
                        2: delta = $urandom;
                        3, 4: delta = $urandom_range(0, 100000);
                        default: begin
                            delta = wait_ms * 1000 - elapsed_us;
                            if (delta > 0 && $urandom_range(0, 3) == 0) delta = delta - 1;
                        end
                    endcase
                    send_tick(delta);
                end
                ticks++;
            end
            if (melody_running && $urandom_range(0, 1) == 0) begin
                send_request(random_request(ACT_STOP));
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_after_reset();
        test_length_extremes();
        test_table_edges();
        test_backpressure();
        test_random_melodies(1500);
        wait_idle();
        if (tone_mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/tms_pkg.sv
hw/rtl/tms_ram.sv
hw/rtl/tms_div.sv
hw/rtl/tms_regs.sv
hw/rtl/tms_ctrl.sv
hw/rtl/tms_dp.sv
hw/rtl/tone_melody_sequencer.sv
hw/rtl/tms_checker.sv
tb/tb_top.sv
